>>> hw/rtl/fls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fls_pkg
// types and constants shared by the flash log segment selector
// ----------------------------------------------------------------------------
package fls_pkg;

    localparam int LEN_W   = 11;
    localparam int SLOT_W  = 6;
    localparam int TOTAL_W = 17;
    localparam int SEGT_W  = 7;

    localparam logic [31:0] ID_END       = 32'hffff_ffff;
    localparam logic [31:0] SEG_CLEARED  = 32'hffff_ffff;
    localparam logic [31:0] TARGET_RESET = 32'h0000_01ff;
    localparam logic [31:0] SECTOR_BYTES = 32'h0000_0800;
    localparam logic [31:0] HEADER_BYTES = 32'h0000_0018;
    localparam logic [31:0] MAX_PAYLOAD  = SECTOR_BYTES - HEADER_BYTES;

    localparam logic MODE_FINISH = 1'b1;

    typedef enum logic [3:0] {
        ACT_SKIPPED      = 4'd0,
        ACT_INCONSISTENT = 4'd1,
        ACT_BLOCK_END    = 4'd2,
        ACT_TOO_LONG     = 4'd3,
        ACT_OTHER_ID     = 4'd4,
        ACT_OBSOLETE     = 4'd5,
        ACT_CLEARED      = 4'd6,
        ACT_STORED       = 4'd7,
        ACT_OVERFLOW     = 4'd8,
        ACT_FINISH       = 4'd9
    } fls_action_t;

    typedef enum logic [0:0] {
        REG_TARGET_ID   = 1'b0,
        REG_CHECK_SPARE = 1'b1
    } fls_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_DROP,
        ST_FINISH,
        ST_REPORT
    } fls_state_t;

    typedef struct packed {
        logic [31:0] target_id;
        logic        check_spare_area;
    } fls_cfg_t;

    typedef struct packed {
        logic             present;
        logic [LEN_W-1:0] length;
    } fls_entry_t;

    typedef struct packed {
        logic        mode;
        logic        at_block_start;
        logic        sector_good;
        logic [31:0] spare_id;
        logic [31:0] spare_len;
        logic [31:0] spare_rev;
        logic [31:0] hdr_id;
        logic [31:0] hdr_len;
        logic [31:0] hdr_rev;
        logic [31:0] seg_index;
        logic [31:0] link_seg;
    } fls_item_t;

    typedef struct packed {
        fls_action_t        action;
        logic [SLOT_W-1:0]  slot;
        logic               dropped_older;
        logic               found;
        logic [TOTAL_W-1:0] total_len;
        logic [SEGT_W-1:0]  seg_total;
    } fls_result_t;

    typedef struct packed {
        fls_state_t state;
        logic       overflowed;
    } fls_status_t;

endpackage

>>> hw/rtl/fls_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fls_if
// valid/ready channels for sector header items and selector results
// ----------------------------------------------------------------------------
interface fls_item_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic        at_block_start;
    logic        sector_good;
    logic [31:0] spare_id;
    logic [31:0] spare_len;
    logic [31:0] spare_rev;
    logic [31:0] hdr_id;
    logic [31:0] hdr_len;
    logic [31:0] hdr_rev;
    logic [31:0] seg_index;
    logic [31:0] link_seg;

    modport source (
        output valid, mode, at_block_start, sector_good, spare_id, spare_len, spare_rev,
               hdr_id, hdr_len, hdr_rev, seg_index, link_seg,
        input  ready
    );
    modport sink (
        input  valid, mode, at_block_start, sector_good, spare_id, spare_len, spare_rev,
               hdr_id, hdr_len, hdr_rev, seg_index, link_seg,
        output ready
    );
endinterface

interface fls_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic [5:0]  slot;
    logic        dropped_older;
    logic        found;
    logic [16:0] total_len;
    logic [6:0]  seg_total;

    modport source (
        output valid, action, slot, dropped_older, found, total_len, seg_total,
        input  ready
    );
    modport sink (
        input  valid, action, slot, dropped_older, found, total_len, seg_total,
        output ready
    );
endinterface

>>> hw/rtl/flash_log_segment_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_log_segment_selector
// keeps the newest revision's segments of one key id from a stream of
// decoded sector headers and reports the assembled entry on finish
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  item      in   valid/ready        mode, sector flags, spare and header words
//  result    out  valid/ready        action, slot, dropped_older, found, totals
//  cfg       in   cfg_we             cfg_index, cfg_data
//
//  header transaction: capture, then evaluate, with the result register free
//  newer revision: a drop pass first clears each kept segment from the store
//  finish transaction: one read per slot, then the report
//  after reset: store clearing over all MAX_SEGMENTS slots with item.ready low
//  a result waiting in its output register holds the next transaction in
//  evaluate or report
// ----------------------------------------------------------------------------
module flash_log_segment_selector
    import fls_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [0:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    fls_item_if.sink      item,
    fls_result_if.source  result
);

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    logic [31:0]  target_id_reg;
    logic         check_spare_reg;
    fls_cfg_t     cfg;
    fls_status_t  status;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    fls_entry_t    mem_wdata;
    logic [AW-1:0] mem_raddr;
    fls_entry_t    mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_id_reg   <= TARGET_RESET;
            check_spare_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET_ID:
                begin
                    target_id_reg <= cfg_data;
                end
                REG_CHECK_SPARE:
                begin
                    check_spare_reg <= cfg_data[0];
                end
                default:
                begin
                    target_id_reg <= target_id_reg;
                end
            endcase
        end
    end

    assign cfg.target_id        = target_id_reg;
    assign cfg.check_spare_area = check_spare_reg;

    fls_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .item      (item),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .status    (status)
    );

    fls_seg_mem #(
        .DEPTH (MAX_SEGMENTS)
    ) u_seg_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // one transaction in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> !item.ready)
        else $error("item accepted twice in a row");

    // no transaction during the store clearing pass
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        status.state == ST_CLEAR |-> !item.ready)
        else $error("item ready during store clearing");

    // overflow result always leaves the sticky flag set
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.action == ACT_OVERFLOW |-> status.overflowed)
        else $error("overflow result without overflow flag");

    // report fields stay zero outside finish
    a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.action != ACT_FINISH
        |-> !result.found && result.total_len == '0 && result.seg_total == '0)
        else $error("report fields set on header result");

endmodule

>>> hw/rtl/fls_seg_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fls_seg_mem
// segment store: presence bit and length per slot, one write and one
// registered read per cycle
// ----------------------------------------------------------------------------
module fls_seg_mem
    import fls_pkg::*;
#(
    parameter int   DEPTH = 64,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  fls_entry_t    wdata,
    input  logic [AW-1:0] raddr,
    output fls_entry_t    rdata
);

    fls_entry_t mem_reg [DEPTH];
    fls_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/fls_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fls_ctrl
// header evaluation, revision tracking, store sweeps and finish walk
// ----------------------------------------------------------------------------
module fls_ctrl
    import fls_pkg::*;
#(
    parameter int  MAX_SEGMENTS = 64,
    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
    localparam int CW = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fls_cfg_t            cfg,
    fls_item_if.sink            item,
    fls_result_if.source        result,
    output logic                mem_we,
    output logic [AW-1:0]       mem_waddr,
    output fls_entry_t          mem_wdata,
    output logic [AW-1:0]       mem_raddr,
    input  fls_entry_t          mem_rdata,
    output fls_status_t         status
);

    localparam logic [32:0]   MAX_CNT33 = 33'(MAX_SEGMENTS);
    localparam logic [CW-1:0] LAST_SLOT = CW'(MAX_SEGMENTS - 1);

    fls_state_t          state_reg, state_next;
    fls_item_t           item_reg, item_next;
    logic                blk_end_reg, blk_end_next;
    logic [31:0]         best_rev_reg, best_rev_next;
    logic [CW-1:0]       seg_count_reg, seg_count_next;
    logic                ovf_reg, ovf_next;
    logic                dropped_reg, dropped_next;
    logic [CW-1:0]       walk_reg, walk_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [AW-1:0]       rd_addr_reg, rd_addr_next;
    logic                found_reg, found_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic                out_valid_reg, out_valid_next;
    fls_result_t         out_reg, out_next;

    fls_action_t         hdr_act;
    logic                need_drop;
    logic                set_blk;
    logic                clr_blk;
    logic                set_ovf;
    logic                store;
    logic [32:0]         new_cnt33;
    logic [CW-1:0]       new_cnt;
    logic [CW-1:0]       res_cnt;
    logic                mark;
    logic                is_finish;
    logic                mismatch;
    logic                out_free;
    logic                issue;

    assign is_finish = (item_reg.mode == MODE_FINISH);
    assign out_free  = !out_valid_reg || result.ready;
    assign issue     = (state_reg == ST_FINISH) && (walk_reg < seg_count_reg);
    assign mismatch  = (item_reg.spare_id != item_reg.hdr_id)
                    || (item_reg.spare_len != item_reg.hdr_len)
                    || (item_reg.spare_rev != item_reg.hdr_rev);

    // header decision
    always_comb
    begin
        hdr_act   = ACT_SKIPPED;
        need_drop = 1'b0;
        set_blk   = 1'b0;
        clr_blk   = 1'b0;
        set_ovf   = 1'b0;
        store     = 1'b0;
        new_cnt33 = (item_reg.link_seg == 32'd0) ? ({1'b0, item_reg.seg_index} + 33'd1)
                                                 : ({1'b0, item_reg.link_seg} + 33'd1);
        if (blk_end_reg)
        begin
            clr_blk = item_reg.at_block_start;
        end
        else if (!item_reg.sector_good)
        begin
            hdr_act = ACT_SKIPPED;
        end
        else if (cfg.check_spare_area && mismatch)
        begin
            hdr_act = ACT_INCONSISTENT;
        end
        else if (item_reg.hdr_id == ID_END)
        begin
            hdr_act = ACT_BLOCK_END;
            set_blk = 1'b1;
        end
        else if (item_reg.hdr_len > MAX_PAYLOAD)
        begin
            hdr_act = ACT_TOO_LONG;
        end
        else if (item_reg.hdr_id != cfg.target_id)
        begin
            hdr_act = ACT_OTHER_ID;
        end
        else if (item_reg.hdr_rev < best_rev_reg)
        begin
            hdr_act = ACT_OBSOLETE;
        end
        else if (item_reg.hdr_rev > best_rev_reg)
        begin
            need_drop = 1'b1;
        end
        else if (item_reg.seg_index == SEG_CLEARED)
        begin
            hdr_act = ACT_CLEARED;
        end
        else if (({1'b0, item_reg.seg_index} >= MAX_CNT33) || (new_cnt33 > MAX_CNT33))
        begin
            hdr_act = ACT_OVERFLOW;
            set_ovf = 1'b1;
        end
        else
        begin
            hdr_act = ACT_STORED;
            store   = 1'b1;
        end
    end

    // slots at or above the count stay unmarked: a later growth would clear them
    assign new_cnt = new_cnt33[CW-1:0];
    assign res_cnt = (new_cnt > seg_count_reg) ? new_cnt : seg_count_reg;
    assign mark    = store && (item_reg.seg_index < 32'(res_cnt));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (walk_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (is_finish)
                begin
                    state_next = ST_FINISH;
                end
                else if (need_drop)
                begin
                    state_next = ST_DROP;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DROP:
            begin
                if (walk_reg >= seg_count_reg)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_FINISH:
            begin
                if (!issue && !rd_pend_reg)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and store control
    always_comb
    begin
        item_next      = item_reg;
        blk_end_next   = blk_end_reg;
        best_rev_next  = best_rev_reg;
        seg_count_next = seg_count_reg;
        ovf_next       = ovf_reg;
        dropped_next   = dropped_reg;
        walk_next      = walk_reg;
        rd_pend_next   = 1'b0;
        rd_addr_next   = walk_reg[AW-1:0];
        found_next     = found_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = walk_reg[AW-1:0];
        mem_wdata      = '0;
        mem_raddr      = walk_reg[AW-1:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                walk_next = (walk_reg == LAST_SLOT) ? '0 : walk_reg + CW'(1);
            end
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    item_next.mode           = item.mode;
                    item_next.at_block_start = item.at_block_start;
                    item_next.sector_good    = item.sector_good;
                    item_next.spare_id       = item.spare_id;
                    item_next.spare_len      = item.spare_len;
                    item_next.spare_rev      = item.spare_rev;
                    item_next.hdr_id         = item.hdr_id;
                    item_next.hdr_len        = item.hdr_len;
                    item_next.hdr_rev        = item.hdr_rev;
                    item_next.seg_index      = item.seg_index;
                    item_next.link_seg       = item.link_seg;
                    dropped_next             = 1'b0;
                end
            end
            ST_EVAL:
            begin
                if (is_finish)
                begin
                    found_next = (seg_count_reg != '0) && !ovf_reg;
                    total_next = '0;
                    walk_next  = '0;
                end
                else if (need_drop)
                begin
                    best_rev_next = item_reg.hdr_rev;
                    dropped_next  = 1'b1;
                    walk_next     = '0;
                end
                else if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.action        = hdr_act;
                    out_next.slot          = store ? item_reg.seg_index[SLOT_W-1:0] : '0;
                    out_next.dropped_older = dropped_reg;
                    out_next.found         = 1'b0;
                    out_next.total_len     = '0;
                    out_next.seg_total     = '0;
                    if (clr_blk)
                    begin
                        blk_end_next = 1'b0;
                    end
                    if (set_blk)
                    begin
                        blk_end_next = 1'b1;
                    end
                    if (set_ovf)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (store)
                    begin
                        seg_count_next = res_cnt;
                    end
                    mem_we            = mark;
                    mem_waddr         = item_reg.seg_index[AW-1:0];
                    mem_wdata.present = 1'b1;
                    mem_wdata.length  = item_reg.hdr_len[LEN_W-1:0];
                end
            end
            ST_DROP:
            begin
                if (walk_reg < seg_count_reg)
                begin
                    mem_we    = 1'b1;
                    walk_next = walk_reg + CW'(1);
                end
                else
                begin
                    seg_count_next = '0;
                    walk_next      = '0;
                end
            end
            ST_FINISH:
            begin
                if (issue)
                begin
                    walk_next = walk_reg + CW'(1);
                end
                rd_pend_next = issue;
                if (rd_pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_addr_reg;
                    if (mem_rdata.present)
                    begin
                        total_next = total_reg + TOTAL_W'(mem_rdata.length);
                    end
                    else
                    begin
                        found_next = 1'b0;
                    end
                end
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.action        = ACT_FINISH;
                    out_next.slot          = '0;
                    out_next.dropped_older = 1'b0;
                    out_next.found         = found_reg;
                    out_next.total_len     = total_reg;
                    out_next.seg_total     = SEGT_W'(seg_count_reg);
                    blk_end_next           = 1'b0;
                    best_rev_next          = '0;
                    seg_count_next         = '0;
                    ovf_next               = 1'b0;
                    walk_next              = '0;
                end
            end
            default:
            begin
                walk_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            blk_end_reg   <= 1'b0;
            best_rev_reg  <= '0;
            seg_count_reg <= '0;
            ovf_reg       <= 1'b0;
            dropped_reg   <= 1'b0;
            walk_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            blk_end_reg   <= blk_end_next;
            best_rev_reg  <= best_rev_next;
            seg_count_reg <= seg_count_next;
            ovf_reg       <= ovf_next;
            dropped_reg   <= dropped_next;
            walk_reg      <= walk_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        rd_addr_reg <= rd_addr_next;
        found_reg   <= found_next;
        total_reg   <= total_next;
        out_reg     <= out_next;
    end

    assign item.ready           = (state_reg == ST_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.action        = out_reg.action;
    assign result.slot          = out_reg.slot;
    assign result.dropped_older = out_reg.dropped_older;
    assign result.found         = out_reg.found;
    assign result.total_len     = out_reg.total_len;
    assign result.seg_total     = out_reg.seg_total;

    assign status.state      = state_reg;
    assign status.overflowed = ovf_reg;

endmodule

>>> sim/flash_log_segment_selector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_log_segment_selector_test
// self-checking testbench for the flash log segment selector. a scoreboard
// class carries its own copy of the selection state, predicts the action,
// slot and finish report of every accepted sector header and compares each
// result in order. a short directed run covers the corner cases, then random
// entries of shuffled segments with noise sectors mixed in run under several
// register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module flash_log_segment_selector_test;
    import fls_pkg::*;

    localparam int SEG_SLOTS     = 64;
    localparam int SEG_AW        = $clog2(SEG_SLOTS);
    localparam int ITEM_TARGET   = 1750;
    localparam int DRAIN_CYCLES  = 90;
    localparam int WATCHDOG_LIMIT = 4000;

    class selector_scoreboard;
        logic [31:0]      target_id;
        logic             check_spare;
        logic             in_block_end;
        logic [31:0]      best_rev;
        int unsigned      seg_count;
        logic             seg_present [SEG_SLOTS];
        logic [LEN_W-1:0] seg_length [SEG_SLOTS];
        logic             overflowed;
        fls_result_t      pending_reports [$];
        int               errors;

        function new();
            target_id   = TARGET_RESET;
            check_spare = 1'b0;
            errors      = 0;
            clear_entry();
        endfunction

        function void clear_entry();
            in_block_end = 1'b0;
            best_rev     = '0;
            seg_count    = 0;
            overflowed   = 1'b0;
            foreach (seg_present[i])
                seg_present[i] = 1'b0;
        endfunction

        function void write_reg(fls_reg_t idx, logic [31:0] data);
            case (idx)
                REG_TARGET_ID:   target_id = data;
                REG_CHECK_SPARE: check_spare = data[0];
                default:         ;
            endcase
        endfunction

        function fls_result_t select_segment(fls_item_t it);
            fls_result_t       r;
            logic [32:0]       grow;
            logic [TOTAL_W-1:0] total;
            int unsigned       i;
            r = '0;
            r.action = ACT_SKIPPED;
            if (it.mode == MODE_FINISH)
            begin
                total = '0;
                r.action    = ACT_FINISH;
                r.seg_total = seg_count[SEGT_W-1:0];
                r.found     = (seg_count != 0) && !overflowed;
                for (i = 0; i < seg_count; i++)
                begin
                    if (seg_present[i])
                        total = total + TOTAL_W'(seg_length[i]);
                    else
                        r.found = 1'b0;
                end
                r.total_len = total;
                clear_entry();
                return r;
            end
            if (in_block_end)
            begin
                if (it.at_block_start)
                    in_block_end = 1'b0;
                return r;
            end
            if (!it.sector_good)
                return r;
            if (check_spare && (it.spare_id != it.hdr_id || it.spare_len != it.hdr_len
                                || it.spare_rev != it.hdr_rev))
            begin
                r.action = ACT_INCONSISTENT;
                return r;
            end
            if (it.hdr_id == ID_END)
            begin
                in_block_end = 1'b1;
                r.action = ACT_BLOCK_END;
                return r;
            end
            if (it.hdr_len > MAX_PAYLOAD)
            begin
                r.action = ACT_TOO_LONG;
                return r;
            end
            if (it.hdr_id != target_id)
            begin
                r.action = ACT_OTHER_ID;
                return r;
            end
            if (it.hdr_rev < best_rev)
            begin
                r.action = ACT_OBSOLETE;
                return r;
            end
            if (it.hdr_rev > best_rev)
            begin
                best_rev  = it.hdr_rev;
                seg_count = 0;
                foreach (seg_present[j])
                    seg_present[j] = 1'b0;
                r.dropped_older = 1'b1;
            end
            if (it.seg_index == SEG_CLEARED)
            begin
                r.action = ACT_CLEARED;
                return r;
            end
            grow = (it.link_seg == 0) ? {1'b0, it.seg_index} + 33'd1
                                      : {1'b0, it.link_seg} + 33'd1;
            if (it.seg_index >= SEG_SLOTS || grow > SEG_SLOTS)
            begin
                overflowed = 1'b1;
                r.action = ACT_OVERFLOW;
                return r;
            end
            if (grow > seg_count)
            begin
                for (i = seg_count; i < grow; i++)
                    seg_present[i] = 1'b0;
                seg_count = grow[31:0];
            end
            seg_present[it.seg_index[SEG_AW-1:0]] = 1'b1;
            seg_length[it.seg_index[SEG_AW-1:0]]  = it.hdr_len[LEN_W-1:0];
            r.slot   = it.seg_index[SLOT_W-1:0];
            r.action = ACT_STORED;
            return r;
        endfunction

        function void note_item(fls_item_t it);
            pending_reports.push_back(select_segment(it));
        endfunction

        function void field_check(string name, logic [31:0] exp, logic [31:0] got);
            if (exp !== got)
            begin
                $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp, got);
                errors++;
            end
        endfunction

        function void check_report(fls_result_t got);
            fls_result_t exp;
            if (pending_reports.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual action %0d",
                         $time, got.action);
                errors++;
                return;
            end
            exp = pending_reports.pop_front();
            field_check("action", exp.action, got.action);
            field_check("slot", exp.slot, got.slot);
            field_check("dropped_older", exp.dropped_older, got.dropped_older);
            field_check("found", exp.found, got.found);
            field_check("total_len", exp.total_len, got.total_len);
            field_check("seg_total", exp.seg_total, got.seg_total);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;

    fls_item_if   item_ch ();
    fls_result_if result_ch ();

    selector_scoreboard board;
    logic [31:0]        cur_target;
    logic [31:0]        entry_rev;
    bit                 item_calm;
    bit                 result_calm;
    int                 items_sent;
    int                 idle_cycles = 0;

    flash_log_segment_selector #(
        .MAX_SEGMENTS (SEG_SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic fls_item_t random_item();
        fls_item_t it;
        it.mode           = 1'($urandom_range(0, 1));
        it.at_block_start = 1'($urandom_range(0, 1));
        it.sector_good    = 1'($urandom_range(0, 1));
        it.spare_id       = $urandom;
        it.spare_len      = $urandom;
        it.spare_rev      = $urandom;
        it.hdr_id         = $urandom;
        it.hdr_len        = $urandom;
        it.hdr_rev        = $urandom;
        it.seg_index      = $urandom;
        it.link_seg       = $urandom;
        return it;
    endfunction

    function automatic fls_item_t sector(logic [31:0] id, logic [31:0] len, logic [31:0] rev,
                                         logic [31:0] seg, logic [31:0] nxt);
        fls_item_t it;
        it.mode           = 1'b0;
        it.at_block_start = 1'($urandom_range(0, 1));
        it.sector_good    = 1'b1;
        it.hdr_id         = id;
        it.hdr_len        = len;
        it.hdr_rev        = rev;
        it.seg_index      = seg;
        it.link_seg       = nxt;
        it.spare_id       = id;
        it.spare_len      = len;
        it.spare_rev      = rev;
        return it;
    endfunction

    function automatic fls_item_t finish_item();
        fls_item_t it;
        it = random_item();
        it.mode = MODE_FINISH;
        return it;
    endfunction

    function automatic logic [31:0] pick_len();
        return ($urandom_range(0, 7) == 0) ? MAX_PAYLOAD : $urandom_range(0, MAX_PAYLOAD);
    endfunction

    task automatic push_item(input fls_item_t it);
        int gap;
        gap = item_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.mode           <= it.mode;
        item_ch.at_block_start <= it.at_block_start;
        item_ch.sector_good    <= it.sector_good;
        item_ch.spare_id       <= it.spare_id;
        item_ch.spare_len      <= it.spare_len;
        item_ch.spare_rev      <= it.spare_rev;
        item_ch.hdr_id         <= it.hdr_id;
        item_ch.hdr_len        <= it.hdr_len;
        item_ch.hdr_rev        <= it.hdr_rev;
        item_ch.seg_index      <= it.seg_index;
        item_ch.link_seg       <= it.link_seg;
        @(posedge clk);
        while (item_ch.ready !== 1'b1)
            @(posedge clk);
        board.note_item(it);
        items_sent++;
    endtask

    task automatic configure(input logic [31:0] target, input logic check);
        item_ch.valid <= 1'b0;
        while (board.pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TARGET_ID;
        cfg_data  <= target;
        @(posedge clk);
        board.write_reg(REG_TARGET_ID, target);
        cfg_index <= REG_CHECK_SPARE;
        cfg_data  <= {31'd0, check};
        @(posedge clk);
        board.write_reg(REG_CHECK_SPARE, {31'd0, check});
        cfg_we     <= 1'b0;
        cur_target = target;
    endtask

    task automatic run_directed();
        fls_item_t it;
        configure(TARGET_RESET, 1'b1);
        push_item(sector(cur_target, MAX_PAYLOAD, 5, 0, 1));
        push_item(sector(cur_target, 0, 5, 1, 0));
        push_item(finish_item());
        push_item(sector(cur_target, MAX_PAYLOAD + 1, 1, 0, 0));
        push_item(sector(cur_target, 32'hffff_ffff, 1, 0, 0));
        it = sector(cur_target, 10, 1, 0, 0);
        it.spare_rev = it.spare_rev ^ 32'h8000_0000;
        push_item(it);
        it = sector(cur_target, 10, 1, 0, 0);
        it.sector_good = 1'b0;
        push_item(it);
        push_item(sector(cur_target ^ 32'd1, 10, 1, 0, 0));
        push_item(sector(cur_target, 100, 32'hffff_ffff, SEG_SLOTS - 1, 0));
        push_item(sector(cur_target, 100, 7, 0, 0));
        push_item(sector(cur_target, 10, 32'hffff_ffff, SEG_CLEARED, 0));
        push_item(sector(cur_target, 10, 32'hffff_ffff, SEG_SLOTS, 0));
        push_item(sector(cur_target, 10, 32'hffff_ffff, 0, 32'hffff_ffff));
        push_item(sector(cur_target, 10, 32'hffff_ffff, 0, SEG_SLOTS));
        push_item(finish_item());
        push_item(sector(ID_END, 0, 0, 0, 0));
        it = sector(cur_target, 8, 0, 0, 0);
        it.at_block_start = 1'b0;
        push_item(it);
        it.at_block_start = 1'b1;
        push_item(it);
        push_item(sector(cur_target, 8, 0, 0, 0));
        push_item(sector(cur_target, 8, 3, 2, 0));
        push_item(sector(cur_target, 8, 3, 5, 1));
        push_item(finish_item());
        push_item(finish_item());
    endtask

    task automatic send_noise(input int unsigned count);
        fls_item_t   it;
        logic [31:0] rev;
        int          n;
        case ($urandom_range(0, 9))
            0:
            begin
                it = random_item();
                it.mode = 1'b0;
                it.sector_good = 1'b0;
                push_item(it);
            end
            1:
            begin
                it = sector($urandom, pick_len(), entry_rev, 0, 0);
                if (it.hdr_id == cur_target)
                    it.hdr_id = cur_target ^ 32'd1;
                it.spare_id = it.hdr_id;
                push_item(it);
            end
            2:
                push_item(sector(cur_target, $urandom_range(MAX_PAYLOAD + 1, 32'hffff_ffff),
                                 entry_rev, $urandom_range(0, count - 1), 0));
            3:
            begin
                push_item(sector(ID_END, pick_len(), $urandom, $urandom, $urandom));
                n = $urandom_range(0, 3);
                repeat (n)
                begin
                    it = random_item();
                    it.mode = 1'b0;
                    it.at_block_start = 1'b0;
                    push_item(it);
                end
                it = random_item();
                it.mode = 1'b0;
                it.at_block_start = 1'b1;
                push_item(it);
            end
            4:
                push_item(sector(cur_target, pick_len(), entry_rev, SEG_CLEARED, $urandom));
            5:
            begin
                it = random_item();
                it.mode = 1'b0;
                push_item(it);
            end
            6:
            begin
                if ($urandom_range(0, 1) == 0)
                    it = sector(cur_target, pick_len(), entry_rev,
                                $urandom_range(SEG_SLOTS, 32'hffff_fffe), $urandom);
                else
                    it = sector(cur_target, pick_len(), entry_rev,
                                $urandom_range(0, SEG_SLOTS - 1),
                                $urandom_range(SEG_SLOTS, 32'hffff_ffff));
                push_item(it);
            end
            7:
            begin
                it = sector(cur_target, pick_len(), entry_rev, $urandom_range(0, count - 1), 0);
                case ($urandom_range(0, 2))
                    0:       it.spare_id  = it.spare_id  ^ (32'd1 << $urandom_range(0, 31));
                    1:       it.spare_len = it.spare_len ^ (32'd1 << $urandom_range(0, 31));
                    default: it.spare_rev = it.spare_rev ^ (32'd1 << $urandom_range(0, 31));
                endcase
                push_item(it);
            end
            8:
            begin
                rev = (entry_rev == 0) ? 32'd0 : $urandom_range(0, entry_rev - 1);
                push_item(sector(cur_target, pick_len(), rev, $urandom_range(0, count - 1), 0));
            end
            default:
            begin
                entry_rev = entry_rev + 1;
                push_item(sector(cur_target, pick_len(), entry_rev,
                                 $urandom_range(0, count - 1), 0));
            end
        endcase
    endtask

    task automatic send_entry();
        int unsigned count;
        int unsigned skip;
        int unsigned k;
        int unsigned j;
        int unsigned swap;
        int unsigned seg;
        int unsigned order [SEG_SLOTS];
        logic [31:0] nxt;
        item_calm = ($urandom_range(0, 3) == 0);
        count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, SEG_SLOTS)
                                            : $urandom_range(1, 6);
        entry_rev = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20);
        skip = ($urandom_range(0, 7) == 0) ? $urandom_range(0, count - 1) : SEG_SLOTS;
        for (k = 0; k < count; k++)
            order[k] = k;
        for (k = count - 1; k > 0; k--)
        begin
            j        = $urandom_range(0, k);
            swap     = order[k];
            order[k] = order[j];
            order[j] = swap;
        end
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_noise(count);
            seg = order[k];
            if (seg != skip)
            begin
                nxt = (seg == count - 1 || $urandom_range(0, 7) == 0) ? 32'd0 : seg + 1;
                push_item(sector(cur_target, pick_len(), entry_rev, seg, nxt));
            end
        end
        push_item(finish_item());
    endtask

    // result side: random back-pressure with occasional stretches of none
    initial
    begin
        fls_result_t got;
        int          gap;
        result_ch.ready <= 1'b0;
        result_calm = 1'b0;
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                result_calm = !result_calm;
            gap = result_calm ? 0 : $urandom_range(0, 13);
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (result_ch.valid !== 1'b1)
                @(posedge clk);
            got.action        = fls_action_t'(result_ch.action);
            got.slot          = result_ch.slot;
            got.dropped_older = result_ch.dropped_older;
            got.found         = result_ch.found;
            got.total_len     = result_ch.total_len;
            got.seg_total     = result_ch.seg_total;
            board.check_report(got);
        end
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1)
            || (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("flash_log_segment_selector_test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int phase;
        board       = new();
        items_sent  = 0;
        item_calm   = 1'b0;
        cur_target  = TARGET_RESET;
        entry_rev   = '0;
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= REG_TARGET_ID;
        cfg_data               <= '0;
        item_ch.valid          <= 1'b0;
        item_ch.mode           <= 1'b0;
        item_ch.at_block_start <= 1'b0;
        item_ch.sector_good    <= 1'b0;
        item_ch.spare_id       <= '0;
        item_ch.spare_len      <= '0;
        item_ch.spare_rev      <= '0;
        item_ch.hdr_id         <= '0;
        item_ch.hdr_len        <= '0;
        item_ch.hdr_rev        <= '0;
        item_ch.seg_index      <= '0;
        item_ch.link_seg       <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (phase)
                0:       configure(32'd0, 1'b0);
                1:       configure(32'hffff_ffff, 1'b1);
                2:       configure(TARGET_RESET, 1'b0);
                default: configure(($urandom_range(0, 3) == 0) ? $urandom
                                                               : $urandom_range(0, 7),
                                   $urandom_range(0, 1));
            endcase
            repeat ($urandom_range(2, 6))
                send_entry();
            phase++;
        end

        item_ch.valid <= 1'b0;
        while (board.pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("flash_log_segment_selector_test passed");
        else
            $display("flash_log_segment_selector_test failed");
        $finish;
    end

endmodule
